// ----- sv/csh_pkg.sv -----
// ----------------------------------------------------------------------------
// csh_pkg
// Shared widths, register indexes and types of the cushion pixel shader.
// ----------------------------------------------------------------------------
package csh_pkg;

	localparam int PIX_W      = 12;
	localparam int CH_W       = 8;
	localparam int COEF_W     = 32;
	localparam int LIGHT_W    = 16;
	localparam int AMB_W      = 15;
	localparam int NUM_W      = 50;   // signed numerator
	localparam int QNUM_W     = 49;   // positive numerator / quotient
	localparam int SQ_W       = 64;   // radicand
	localparam int ROOT_W     = SQ_W / 2;
	localparam int COSA_W     = 23;
	localparam int PROD_W     = COSA_W + CH_W;
	localparam int LIGHT_FRAC = 14;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_X_LIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_QUAD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_QUAD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LX     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LY     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LZ     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AMB    = 3'd7;

	localparam logic [LIGHT_W-1:0] LZ_RESET = 16'd16384;
	localparam logic [COSA_W-1:0]  COSA_SAT = 23'h400000;
	localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(8192);
	localparam logic [CH_W-1:0]    CH_MAX = 8'hFF;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	localparam int RGB_W = $bits(rgb_t);

endpackage

// ----- sv/cushion_pixel_shader_top.sv -----
// ----------------------------------------------------------------------------
// cushion_pixel_shader_top
// Cushion treemap pixel shader: normal, diffuse light, ambient, RGB scaling.
//
// channel  dir  width  beat
// s_axis   in   48     pixel_x, pixel_y, base_red, base_green, base_blue
// m_axis   out  24     shade_red, shade_green, shade_blue
// cfg      in   3+32   register write, index 0..7
//
// One pixel per clock while the output skid is not full; a pixel passes the front stages,
// the square root, the divider, the scale register and the output register in that order.
// The square root and divider are fully pipelined, one bit per stage.
// Reset clears valid bits and config registers (light_z resets to 1.0).
// A two-entry output (register plus skid) stalls the whole pipeline only once
// both entries hold undelivered beats.
// ----------------------------------------------------------------------------
module cushion_pixel_shader_top
	import csh_pkg::*;
#(
	parameter int COORD_BITS     = 12,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pixel_x[11:0], pixel_y[23:12], base_red, base_green, base_blue
	input  logic [47:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// shade_red[7:0], shade_green[15:8], shade_blue[23:16]
	output logic [23:0]           m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
	localparam logic [SQ_W-1:0] ONE_SQ = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * COEF_FRAC_BITS);
	localparam int SIDE1_W = QNUM_W + RGB_W;

	logic signed [COEF_W-1:0]  x_lin_q, x_quad_q, y_lin_q, y_quad_q;
	logic signed [LIGHT_W-1:0] lx_q, ly_q, lz_q;
	logic [AMB_W-1:0]          amb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lin_q  <= '0;
			x_quad_q <= '0;
			y_lin_q  <= '0;
			y_quad_q <= '0;
			lx_q     <= '0;
			ly_q     <= '0;
			lz_q     <= LZ_RESET;
			amb_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_LIN:  x_lin_q  <= cfg_data;
				REG_X_QUAD: x_quad_q <= cfg_data;
				REG_Y_LIN:  y_lin_q  <= cfg_data;
				REG_Y_QUAD: y_quad_q <= cfg_data;
				REG_LX:     lx_q     <= cfg_data[LIGHT_W-1:0];
				REG_LY:     ly_q     <= cfg_data[LIGHT_W-1:0];
				REG_LZ:     lz_q     <= cfg_data[LIGHT_W-1:0];
				REG_AMB:    amb_q    <= cfg_data[AMB_W-1:0];
				default: ;
			endcase
		end
	end

	logic pipe_en;
	logic skid_vld_q;
	rgb_t skid_q;
	rgb_t out_q;
	logic out_vld_q;

	assign pipe_en       = !skid_vld_q;
	assign s_axis_tready = pipe_en;

	// front stages
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	rgb_t rgb_s1, rgb_s2, rgb_s3, rgb_s4;
	rgb_t rgb_in;
	logic signed [COEF_W-1:0] nx_s2, ny_s2;

	assign rgb_in.red   = s_axis_tdata[31:24];
	assign rgb_in.green = s_axis_tdata[39:32];
	assign rgb_in.blue  = s_axis_tdata[47:40];

	csh_normal #(.CW(CW)) u_nx (
		.clk   (clk),
		.en    (pipe_en),
		.lin   (x_lin_q),
		.quad  (x_quad_q),
		.coord (s_axis_tdata[CW-1:0]),
		.n_s2  (nx_s2)
	);

	csh_normal #(.CW(CW)) u_ny (
		.clk   (clk),
		.en    (pipe_en),
		.lin   (y_lin_q),
		.quad  (y_quad_q),
		.coord (s_axis_tdata[PIX_W+CW-1:PIX_W]),
		.n_s2  (ny_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	logic [COEF_W-1:0]          ax, ay;
	logic [SQ_W-1:0]            sqx_s3, sqy_s3, sum_s4;
	logic signed [47:0]         px_s3, py_s3;
	logic signed [NUM_W-1:0]    num;
	logic [QNUM_W-1:0]          numpos_s4;

	assign ax  = nx_s2[COEF_W-1] ? COEF_W'(-nx_s2) : nx_s2;
	assign ay  = ny_s2[COEF_W-1] ? COEF_W'(-ny_s2) : ny_s2;
	assign num = (NUM_W'(lz_q) <<< COEF_FRAC_BITS) + NUM_W'(py_s3) + NUM_W'(px_s3);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rgb_s1    <= rgb_in;
			rgb_s2    <= rgb_s1;
			rgb_s3    <= rgb_s2;
			rgb_s4    <= rgb_s3;
			sqx_s3    <= ax * ax;
			sqy_s3    <= ay * ay;
			px_s3     <= lx_q * nx_s2;
			py_s3     <= ly_q * ny_s2;
			sum_s4    <= sqx_s3 + sqy_s3 + ONE_SQ;
			numpos_s4 <= (num > 0) ? num[QNUM_W-1:0] : '0;
		end
	end

	// square root and divide
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	logic [SIDE1_W-1:0] sq_side;

	csh_sqrt #(.W(SQ_W), .SIDE_W(SIDE1_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_vld   (vld_s4),
		.in_rad   (sum_s4),
		.in_side  ({numpos_s4, rgb_s4}),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	logic              dv_vld;
	logic [QNUM_W-1:0] dv_quo;
	rgb_t              dv_rgb;

	csh_div #(.NW(QNUM_W), .DW(ROOT_W), .SIDE_W(RGB_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_vld   (sq_vld),
		.in_num   (sq_side[SIDE1_W-1:RGB_W]),
		.in_den   (sq_root),
		.in_side  (sq_side[RGB_W-1:0]),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_rgb)
	);

	// ambient and clamp
	logic [QNUM_W:0]   cosa;
	logic              vld_sc;
	logic [COSA_W-1:0] cosa_sc;
	rgb_t              rgb_sc;

	assign cosa = (QNUM_W+1)'(amb_q) + (QNUM_W+1)'(dv_quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sc <= 1'b0;
		else if (pipe_en)
			vld_sc <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			cosa_sc <= (|cosa[QNUM_W:COSA_W-1]) ? COSA_SAT : cosa[COSA_W-1:0];
			rgb_sc  <= dv_rgb;
		end
	end

	function automatic logic [CH_W-1:0] shade_ch(input logic [COSA_W-1:0] c,
			input logic [CH_W-1:0] b);
		logic [PROD_W-1:0] p;
		logic [PROD_W-LIGHT_FRAC-1:0] v;
		p = PROD_W'(c) * PROD_W'(b) + ROUND_HALF;
		v = p[PROD_W-1:LIGHT_FRAC];
		return (v > (PROD_W-LIGHT_FRAC)'(CH_MAX)) ? CH_MAX : v[CH_W-1:0];
	endfunction

	rgb_t shade;
	logic deliver;

	assign shade.red   = shade_ch(cosa_sc, rgb_sc.red);
	assign shade.green = shade_ch(cosa_sc, rgb_sc.green);
	assign shade.blue  = shade_ch(cosa_sc, rgb_sc.blue);
	assign deliver     = pipe_en && vld_sc;

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_axis_tready) begin
			out_vld_q  <= skid_vld_q || deliver;
			skid_vld_q <= 1'b0;
		end else if (deliver) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready)
			out_q <= skid_vld_q ? skid_q : shade;
		else if (deliver)
			skid_q <= shade;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_q.blue, out_q.green, out_q.red};

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready && vld_sc))
		else $error("skid filled without a stalled output");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && m_axis_tready) |=> (out_vld_q && !skid_vld_q))
		else $error("skid beat not moved to output");

endmodule

// ----- sv/csh_normal.sv -----
// ----------------------------------------------------------------------------
// csh_normal
// Two-stage normal component: lin + quad*(2*coord+1), saturated to 32 bits.
// ----------------------------------------------------------------------------
module csh_normal
	import csh_pkg::*;
#(
	parameter int CW = 12
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [COEF_W-1:0] lin,
	input  logic signed [COEF_W-1:0] quad,
	input  logic [CW-1:0]            coord,
	output logic signed [COEF_W-1:0] n_s2
);

	localparam int PW = COEF_W + CW + 2;

	logic signed [PW-1:0]   prod_s1;
	logic signed [PW:0]     sum;
	logic signed [CW+1:0]   odd;

	assign odd = {1'b0, coord, 1'b1};
	assign sum = (PW+1)'(lin) + (PW+1)'(prod_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(quad) * PW'(odd);
			if (sum > (PW+1)'(32'sh7FFFFFFF))
				n_s2 <= 32'sh7FFFFFFF;
			else if (sum < -(PW+1)'(33'sh080000000))
				n_s2 <= 32'sh80000000;
			else
				n_s2 <= sum[COEF_W-1:0];
		end
	end

endmodule

// ----- sv/csh_sqrt.sv -----
// ----------------------------------------------------------------------------
// csh_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module csh_sqrt
	import csh_pkg::*;
#(
	parameter int W      = 64,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [W-1:0]      in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [W/2-1:0]    out_root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int N = W / 2;

	logic [W-1:0]      rad_s  [0:N];
	logic [W-1:0]      root_s [0:N];
	logic [SIDE_W-1:0] side_s [0:N];
	logic              vld_s  [0:N];

	assign rad_s[0]  = in_rad;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [W-1:0] BITK = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
		logic [W-1:0] trial;
		logic         ge;

		assign trial = root_s[k] + BITK;
		assign ge    = rad_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= ge ? rad_s[k] - trial : rad_s[k];
				root_s[k+1] <= ge ? (root_s[k] >> 1) + BITK : root_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N][W/2-1:0];
	assign out_side = side_s[N];

endmodule

// ----- sv/csh_div.sv -----
// ----------------------------------------------------------------------------
// csh_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module csh_div
	import csh_pkg::*;
#(
	parameter int NW     = 49,
	parameter int DW     = 32,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NW-1:0]     in_num,
	input  logic [DW-1:0]     in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [NW-1:0]     out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic [DW-1:0]     rem_s  [0:NW];
	logic [NW-1:0]     nq_s   [0:NW];
	logic [DW-1:0]     den_s  [0:NW];
	logic [SIDE_W-1:0] side_s [0:NW];
	logic              vld_s  [0:NW];

	assign rem_s[0]  = '0;
	assign nq_s[0]   = in_num;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar i = 0; i < NW; i++) begin : g_step
		logic [DW:0]   t;
		logic [DW:0]   diff;
		logic          ge;

		assign t    = {rem_s[i], nq_s[i][NW-1]};
		assign diff = t - {1'b0, den_s[i]};
		assign ge   = t >= {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
				nq_s[i+1]   <= {nq_s[i][NW-2:0], ge};
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[NW];
	assign out_quo  = nq_s[NW];
	assign out_side = side_s[NW];

endmodule

// ----- sim/tb_cushion_pixel_shader_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cushion_pixel_shader_top
// Self-checking bench for the cushion treemap pixel shader.
//
// A scoreboard class keeps its own copy of the shading registers and
// predicts every output beat from the accepted input beat. It works in
// 64-bit integer math: normal, exact square root, divide, ambient, rounding
// and saturation. Stimulus starts with a few directed pixels under
// boundary settings. Random register sets and pixels follow, run with
// phases of idle and stall on both stream sides.
// ----------------------------------------------------------------------------
module tb_cushion_pixel_shader_top;
	import csh_pkg::*;

	localparam int HOLD_CYCLES = 100;
	localparam int STALL_LIMIT = 5000;

	class shade_scoreboard;
		logic [COEF_W-1:0]  x_lin, x_quad, y_lin, y_quad;
		logic [LIGHT_W-1:0] lx, ly, lz;
		logic [AMB_W-1:0]   amb;
		rgb_t               pending[$];
		int                 mismatches;
		int                 checked;

		function new();
			x_lin = '0; x_quad = '0; y_lin = '0; y_quad = '0;
			lx = '0; ly = '0; lz = LZ_RESET; amb = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_X_LIN:  x_lin = val;
				REG_X_QUAD: x_quad = val;
				REG_Y_LIN:  y_lin = val;
				REG_Y_QUAD: y_quad = val;
				REG_LX:     lx = val[LIGHT_W-1:0];
				REG_LY:     ly = val[LIGHT_W-1:0];
				REG_LZ:     lz = val[LIGHT_W-1:0];
				REG_AMB:    amb = val[AMB_W-1:0];
				default: ;
			endcase
		endfunction

		function longint normal(logic [COEF_W-1:0] lin, logic [COEF_W-1:0] quad,
			logic [PIX_W-1:0] c);
			longint n;
			longint l, q;
			l = longint'($signed(lin));
			q = longint'($signed(quad));
			n = l + q * (2 * longint'({1'b0, c}) + 1);
			if (n > 64'sd2147483647)
				n = 64'sd2147483647;
			if (n < -64'sd2147483648)
				n = -64'sd2147483648;
			return n;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function logic [CH_W-1:0] scale(longint unsigned cosa, logic [CH_W-1:0] base);
			longint unsigned v;
			v = (cosa * longint'({1'b0, base}) + 8192) >> LIGHT_FRAC;
			return (v > 255) ? CH_MAX : v[CH_W-1:0];
		endfunction

		function void note_pixel(logic [47:0] beat);
			longint nx, ny, num;
			longint unsigned ax, ay, den, diffuse, cosa;
			rgb_t exp_rgb;
			nx = normal(x_lin, x_quad, beat[11:0]);
			ny = normal(y_lin, y_quad, beat[23:12]);
			num = longint'($signed(lz)) * 65536 + longint'($signed(ly)) * ny
				+ longint'($signed(lx)) * nx;
			ax = (nx < 0) ? -nx : nx;
			ay = (ny < 0) ? -ny : ny;
			den = root(ax * ax + ay * ay + (64'd1 << 32));
			diffuse = 0;
			if (num > 0 && den != 0)
				diffuse = longint'(num) / den;
			cosa = longint'({1'b0, amb}) + diffuse;
			exp_rgb.red = scale(cosa, beat[31:24]);
			exp_rgb.green = scale(cosa, beat[39:32]);
			exp_rgb.blue = scale(cosa, beat[47:40]);
			pending.push_back(exp_rgb);
		endfunction

		function void check_shade(logic [23:0] beat);
			rgb_t got, want;
			got = beat;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected output beat %h", beat);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: beat %0d rgb expected %0d/%0d/%0d got %0d/%0d/%0d",
						checked, want.red, want.green, want.blue,
						got.red, got.green, got.blue);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [47:0]           s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [23:0]           m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	shade_scoreboard sb;
	int gap_pct;
	int stall_pct;
	int quiet_cycles;
	int sent;

	cushion_pixel_shader_top dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_pixel(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_shade(m_axis_tdata);
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired with %0d beats outstanding", sb.pending.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// called at a rising edge; returns at the edge that accepts the beat
	task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
		logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, g, r, py, px};
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		sent++;
	endtask

	task automatic send_random_pixel();
		send_pixel(PIX_W'($urandom_range(4095)), PIX_W'($urandom_range(4095)),
			CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
			CH_W'($urandom_range(255)));
	endtask

	// let the pipe drain before touching registers
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
	endtask

	task automatic write_all(logic [31:0] xl, logic [31:0] xq, logic [31:0] yl,
		logic [31:0] yq, logic [15:0] lxv, logic [15:0] lyv, logic [15:0] lzv,
		logic [14:0] ambv);
		write_reg(REG_X_LIN, xl);
		write_reg(REG_X_QUAD, xq);
		write_reg(REG_Y_LIN, yl);
		write_reg(REG_Y_QUAD, yq);
		write_reg(REG_LX, {16'd0, lxv});
		write_reg(REG_LY, {16'd0, lyv});
		write_reg(REG_LZ, {16'd0, lzv});
		write_reg(REG_AMB, {17'd0, ambv});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_signed(int mag_bits);
		int unsigned m;
		m = $urandom_range((1 << mag_bits) - 1);
		return $urandom_range(1) ? -m : m;
	endfunction

	initial begin
		int phase;
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gap_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		sent = 0;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: flat cushion, light straight down
		send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd0, 12'd4095, 8'd255, 8'd0, 8'd128);
		send_pixel(12'd2048, 12'd1, 8'd1, 8'd127, 8'd254);
		drain();

		// huge normals saturate, bright ambient
		write_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			16'h8000, 16'h7FFF, 16'h7FFF, 15'h7FFF);
		send_pixel(12'd0, 12'd0, 8'd255, 8'd1, 8'd128);
		send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd1234, 12'd3000, 8'd0, 8'd64, 8'd200);
		drain();

		// negative light_z, saturated normals, no ambient
		write_all(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			16'h7FFF, 16'h8000, 16'h8000, 15'd0);
		send_pixel(12'd0, 12'd4095, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd4095, 12'd0, 8'd200, 8'd100, 8'd50);
		drain();

		// ambient exactly one, typical cushion
		write_all(32'h00020000, 32'hFFFFFF00, 32'hFFFE8000, 32'h00000080,
			16'd9000, 16'hE000, 16'd12000, 15'd16384);
		for (i = 0; i < 8; i++)
			send_random_pixel();
		drain();

		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 56; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 56; end
				default: begin gap_pct = 37; stall_pct = 37; end
			endcase
			if (phase % 3 == 2)
				write_all($urandom(), $urandom(), $urandom(), $urandom(),
					16'($urandom()), 16'($urandom()), 16'($urandom()),
					15'($urandom()));
			else
				write_all(rand_signed(20), rand_signed(12), rand_signed(20), rand_signed(12),
					16'(rand_signed(14)), 16'(rand_signed(14)),
					16'($urandom_range(32767)),
					15'($urandom_range(phase % 2 ? 32767 : 8192)));
			for (i = 0; i < 165; i++)
				send_random_pixel();
			gap_pct = 0;
			stall_pct = 0;
			drain();
		end

		$display("Shaded %0d pixels over 12 register settings, saturating and zero-light cases",
			sent);
		$display("included, with idle and stall phases on both stream sides");
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- cushion_pixel_shader_top.f -----
sv/csh_pkg.sv
sv/csh_normal.sv
sv/csh_sqrt.sv
sv/csh_div.sv
sv/cushion_pixel_shader_top.sv
sim/tb_cushion_pixel_shader_top.sv
